// ===== rtl/eos_pkg.sv =====
// Shared types, operation codes and slot masks of the elevator order scheduler.
// No dependencies; used by eos_table, elevator_order_scheduler_core and the testbench.
package eos_pkg;

   localparam int NumSlots      = 12;
   localparam int SlotIdxWidth  = 4;
   localparam int FloorWidth    = 2;
   localparam int ReqDataWidth  = 16;
   localparam int RspDataWidth  = 8;

   typedef logic [2:0]                opcode_type;
   typedef logic [NumSlots-1:0]       flags_type;
   typedef logic [FloorWidth-1:0]     floor_type;
   typedef logic signed [1:0]         dir_type;

   // operation codes
   localparam opcode_type OP_ADD_ORDER   = 3'd0;
   localparam opcode_type OP_CLEAR_FLOOR = 3'd1;
   localparam opcode_type OP_CLEAR_ALL   = 3'd2;
   localparam opcode_type OP_DIRECTION   = 3'd3;
   localparam opcode_type OP_BETWEEN     = 3'd4;
   localparam opcode_type OP_STOP_CHECK  = 3'd5;

   // direction codes
   localparam dir_type DIR_DOWN = 2'sb11;
   localparam dir_type DIR_NONE = 2'sb00;
   localparam dir_type DIR_UP   = 2'sb01;

   // floor numbers
   localparam floor_type FLOOR_BOTTOM = 2'd0;
   localparam floor_type FLOOR_LOW    = 2'd1;
   localparam floor_type FLOOR_HIGH   = 2'd2;
   localparam floor_type FLOOR_TOP    = 2'd3;

   // request item, last field in the lowest bits
   typedef struct packed {
      logic                 above_flag;
      dir_type              travel_direction;
      floor_type            floor_number;
      logic [SlotIdxWidth-1:0] order_index;
      opcode_type           opcode;
   } req_item_type;

   // result item, last field in the lowest bits
   typedef struct packed {
      logic    stop_here;
      dir_type new_direction;
   } rsp_item_type;

   // slots lying below the three slots of a floor
   function automatic flags_type below_mask(input floor_type f);
      flags_type m;
      begin
         case (f)
            FLOOR_BOTTOM: m = 12'h000;
            FLOOR_LOW:    m = 12'h007;
            FLOOR_HIGH:   m = 12'h03F;
            default:      m = 12'h1FF;
         endcase
         return m;
      end
   endfunction

   // slots lying above the three slots of a floor
   function automatic flags_type above_mask(input floor_type f);
      flags_type m;
      begin
         case (f)
            FLOOR_BOTTOM: m = 12'hFF8;
            FLOOR_LOW:    m = 12'hFC0;
            FLOOR_HIGH:   m = 12'hE00;
            default:      m = 12'h000;
         endcase
         return m;
      end
   endfunction

endpackage

// ===== rtl/eos_table.sv =====
// Order flag register with its edit and query logic, one item per step.
// Depends on eos_pkg.
module eos_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  eos_pkg::req_item_type item,
   output eos_pkg::rsp_item_type result
);
   import eos_pkg::*;

   flags_type    flags_ff, flags_in;
   flags_type    below, above, in_floor;
   logic         going_down, going_up;
   logic         any_below, any_above, any_set;
   logic         stop;
   dir_type      dir_sel, between_sel;

   // decode travel and slot regions
   assign going_down = item.travel_direction[1];
   assign going_up   = (item.travel_direction == DIR_UP);
   assign below      = below_mask(item.floor_number);
   assign above      = above_mask(item.floor_number);
   assign in_floor   = ~(below | above);
   assign any_below  = |(flags_ff & below);
   assign any_above  = |(flags_ff & above);
   assign any_set    = |flags_ff;

   // table edits
   always_comb begin
      flags_in = flags_ff;
      case (item.opcode)
         OP_ADD_ORDER: begin
            if (item.order_index < SlotIdxWidth'(NumSlots)) begin
               flags_in[item.order_index] = 1'b1;
            end
         end
         OP_CLEAR_FLOOR: flags_in = flags_ff & ~in_floor;
         OP_CLEAR_ALL:   flags_in = '0;
         default:        flags_in = flags_ff;
      endcase
   end

   // direction from last floor: scan order decides which side wins
   always_comb begin
      dir_sel = DIR_NONE;
      if (going_down) begin
         if (any_below)      dir_sel = DIR_DOWN;
         else if (any_above) dir_sel = DIR_UP;
      end else if (going_up) begin
         if (any_above)      dir_sel = DIR_UP;
         else if (any_below) dir_sel = DIR_DOWN;
      end
   end

   // direction while between floors
   always_comb begin
      between_sel = DIR_NONE;
      if (item.above_flag) begin
         if (any_above)    between_sel = DIR_UP;
         else if (any_set) between_sel = DIR_DOWN;
      end else begin
         if (any_below)    between_sel = DIR_DOWN;
         else if (any_set) between_sel = DIR_UP;
      end
   end

   // stop check at the current floor
   always_comb begin
      case (item.floor_number)
         FLOOR_BOTTOM: stop = flags_ff[0] | flags_ff[2];
         FLOOR_LOW:    stop = flags_ff[5] | (going_down & flags_ff[4])
                              | (going_up & flags_ff[3]);
         FLOOR_HIGH:   stop = flags_ff[8] | (going_down & flags_ff[7])
                              | (going_up & flags_ff[6]);
         default:      stop = flags_ff[10] | flags_ff[11];
      endcase
      // turnaround calls when nothing lies further in the travel direction
      if (going_down && item.floor_number == FLOOR_HIGH
          && flags_ff[5:0] == '0 && flags_ff[6]) stop = 1'b1;
      if (going_down && item.floor_number == FLOOR_LOW
          && flags_ff[2:0] == '0 && flags_ff[3]) stop = 1'b1;
      if (going_up && item.floor_number == FLOOR_LOW
          && flags_ff[11:6] == '0 && flags_ff[4]) stop = 1'b1;
      if (going_up && item.floor_number == FLOOR_HIGH
          && flags_ff[11:9] == '0 && flags_ff[7]) stop = 1'b1;
   end

   // result select
   always_comb begin
      result.new_direction = DIR_NONE;
      result.stop_here     = 1'b0;
      case (item.opcode)
         OP_DIRECTION:  result.new_direction = dir_sel;
         OP_BETWEEN:    result.new_direction = between_sel;
         OP_STOP_CHECK: result.stop_here     = stop;
         default:       result.new_direction = DIR_NONE;
      endcase
   end

   // flag register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (step) begin
         flags_ff <= flags_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      step && item.opcode == OP_CLEAR_ALL |=> flags_ff == '0)
      else $error("flags not cleared after clear all");

   a_add_sets: assert property (@(posedge clock) disable iff (reset)
      step && item.opcode == OP_ADD_ORDER && item.order_index < SlotIdxWidth'(NumSlots)
      |=> flags_ff[$past(item.order_index)])
      else $error("added order slot not set");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(flags_ff))
      else $error("flags changed without a step");
`endif

endmodule

// ===== rtl/elevator_order_scheduler_core.sv =====
// Top level of the elevator order scheduler: input register, table, result register.
// Depends on eos_pkg and eos_table.
//
// Order table of a four-floor elevator. Each request beat carries one operation
// (add order, clear floor, clear all, direction, between-floors direction, stop
// check) and yields exactly one response beat. An accepted request beat sits in the
// input register and moves on to the response register, raising rsp_tvalid, once that
// register is empty or being read. The block takes one beat every cycle while the
// consumer keeps up: the edit and query logic on the 12-bit flag register is
// combinational. With a stalled consumer the input and response registers hold two
// beats, after which req_tready drops until a response beat leaves.
module elevator_order_scheduler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode[2:0], order_index[6:3], floor_number[8:7], travel_direction[10:9],
   // above_flag[11], zero[15:12]
   input  logic [eos_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // new_direction[1:0], stop_here[2], zero[7:3]
   output logic [eos_pkg::RspDataWidth-1:0] rsp_tdata
);
   import eos_pkg::*;

   localparam int ReqItemWidth = $bits(req_item_type);
   localparam int RspItemWidth = $bits(rsp_item_type);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type table_result;
   logic         advance, step;

   // pipeline flow control
   assign advance      = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   eos_table u_table (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (table_result)
   );

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_tdata[ReqItemWidth-1:0];
      end
      if (step) begin
         out_item_ff <= table_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-RspItemWidth){1'b0}}, out_item_ff};

`ifndef SYNTHESIS
   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_item_ff.stop_here && out_item_ff.new_direction != DIR_NONE))
      else $error("stop and direction both set");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_item_ff.new_direction != 2'sb10)
      else $error("illegal direction code");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input item lost");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for elevator_order_scheduler_core: directed, random and back-pressure tests.
// Depends on eos_pkg and the core RTL; predicts every reply beat from its own copy of the order table.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import eos_pkg::*;

   // opcodes the block treats as no-ops
   localparam opcode_type OP_SPARE_LOW  = 3'd6;
   localparam opcode_type OP_SPARE_HIGH = 3'd7;
   // travel pattern 2'b10, read as down
   localparam dir_type DIR_MINUS_TWO = 2'sb10;
   localparam int StallLimit = 2000;
   localparam int DrainCycles = 8;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // opcode, order_index, floor_number, travel_direction, above_flag, zero pad
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // new_direction, stop_here, zero pad
   logic [RspDataWidth-1:0] rsp_tdata;

   flags_type    order_table = '0;
   rsp_item_type expected_replies[$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_request = 0;
   int           hold_left = 0;
   int           quiet_cycles = 0;

   elevator_order_scheduler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // direction from last floor and last travel, priority scan over the table
   function automatic dir_type travel_choice(input floor_type lf, input dir_type td);
      int lo;
      int hi;
      int s;
      lo = int'(lf) * 3;
      hi = lo + 2;
      if (td == DIR_NONE) return DIR_NONE;
      for (int k = 0; k < NumSlots; k++) begin
         s = (td == DIR_UP) ? NumSlots - 1 - k : k;
         if (!order_table[s]) continue;
         if (s < lo && lf != FLOOR_BOTTOM) return DIR_DOWN;
         if (s > hi && lf != FLOOR_TOP) return DIR_UP;
      end
      return DIR_NONE;
   endfunction

   // direction while between floors: first set slot in scan order decides
   function automatic dir_type between_choice(input floor_type lf, input logic above);
      int s;
      for (int k = 0; k < NumSlots; k++) begin
         s = above ? NumSlots - 1 - k : k;
         if (!order_table[s]) continue;
         if (!above) return (s < int'(lf) * 3) ? DIR_DOWN : DIR_UP;
         return (s > int'(lf) * 3 + 2) ? DIR_UP : DIR_DOWN;
      end
      return DIR_NONE;
   endfunction

   function automatic logic floor_clear(input int f);
      return order_table[f*3 +: 3] == 3'b000;
   endfunction

   // stop decision at the current floor, including calls the other way
   function automatic logic stop_choice(input floor_type f, input dir_type td);
      logic down;
      logic up;
      down = td[1];
      up = (td == DIR_UP);
      case (f)
         FLOOR_BOTTOM: if (order_table[0] || order_table[2]) return 1'b1;
         FLOOR_LOW: begin
            if (order_table[5] || (down && order_table[4]) || (up && order_table[3]))
               return 1'b1;
         end
         FLOOR_HIGH: begin
            if (order_table[8] || (down && order_table[7]) || (up && order_table[6]))
               return 1'b1;
         end
         default: if (order_table[10] || order_table[11]) return 1'b1;
      endcase
      if (down) begin
         if (f == FLOOR_HIGH && floor_clear(0) && floor_clear(1) && order_table[6]) return 1'b1;
         if (f == FLOOR_LOW && floor_clear(0) && order_table[3]) return 1'b1;
      end
      if (up) begin
         if (f == FLOOR_LOW && floor_clear(2) && floor_clear(3) && order_table[4]) return 1'b1;
         if (f == FLOOR_HIGH && floor_clear(3) && order_table[7]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // apply one request to the table copy and return the reply it should give
   function automatic rsp_item_type apply_order_beat(input req_item_type it);
      rsp_item_type r;
      r = '0;
      case (it.opcode)
         OP_ADD_ORDER: if (it.order_index < NumSlots) order_table[it.order_index] = 1'b1;
         OP_CLEAR_FLOOR: order_table[int'(it.floor_number)*3 +: 3] = 3'b000;
         OP_CLEAR_ALL: order_table = '0;
         OP_DIRECTION: r.new_direction = travel_choice(it.floor_number, it.travel_direction);
         OP_BETWEEN: r.new_direction = between_choice(it.floor_number, it.above_flag);
         OP_STOP_CHECK: r.stop_here = stop_choice(it.floor_number, it.travel_direction);
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // request and reply monitor: predict on request accept, compare on reply accept
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected reply beat, data", int'(rsp_tdata), -1);
            end else begin
               want = expected_replies.pop_front();
               if (got.new_direction !== want.new_direction)
                  report_mismatch("new_direction", int'(got.new_direction),
                                  int'(want.new_direction));
               if (got.stop_here !== want.stop_here)
                  report_mismatch("stop_here", int'(got.stop_here), int'(want.stop_here));
            end
         end
         if (req_tvalid && req_tready)
            expected_replies.push_back(apply_order_beat(req_item_type'(req_tdata[11:0])));
      end
   end

   // reply side ready, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request beat and wait for its accept; valid stays high afterwards
   task automatic send_order(input req_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(ReqDataWidth - $bits(req_item_type)){1'b0}}, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic req_item_type make_beat(input opcode_type op, input int idx,
                                              input floor_type fl, input dir_type td,
                                              input logic above);
      req_item_type it;
      it.opcode = op;
      it.order_index = idx[SlotIdxWidth-1:0];
      it.floor_number = fl;
      it.travel_direction = td;
      it.above_flag = above;
      return it;
   endfunction

   // mostly meaningful operations on a well-filled table, some noise
   function automatic req_item_type random_order_beat();
      req_item_type it;
      int pick;
      logic [31:0] noise;
      noise = $urandom();
      it = noise[$bits(req_item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         it.opcode = OP_ADD_ORDER;
         it.order_index = ($urandom_range(0, 19) == 0)
                          ? SlotIdxWidth'($urandom_range(12, 15))
                          : SlotIdxWidth'($urandom_range(0, 11));
      end else if (pick < 45) it.opcode = OP_CLEAR_FLOOR;
      else if (pick < 48) it.opcode = OP_CLEAR_ALL;
      else if (pick < 65) it.opcode = OP_DIRECTION;
      else if (pick < 80) it.opcode = OP_BETWEEN;
      else if (pick < 97) it.opcode = OP_STOP_CHECK;
      else it.opcode = $urandom_range(0, 1) ? OP_SPARE_LOW : OP_SPARE_HIGH;
      return it;
   endfunction

   task automatic test_directed();
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_BOTTOM, DIR_DOWN, 1'b0));
      send_order(make_beat(OP_DIRECTION, 0, FLOOR_LOW, DIR_UP, 1'b0));
      send_order(make_beat(OP_BETWEEN, 0, FLOOR_HIGH, DIR_NONE, 1'b1));
      // dummy slots, the extremes, and indexes past the table
      send_order(make_beat(OP_ADD_ORDER, 1, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 9, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 12, FLOOR_TOP, DIR_UP, 1'b1));
      send_order(make_beat(OP_ADD_ORDER, 15, FLOOR_TOP, DIR_MINUS_TWO, 1'b1));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_TOP, DIR_UP, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 0, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 11, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_TOP, DIR_MINUS_TWO, 1'b0));
      send_order(make_beat(OP_DIRECTION, 0, FLOOR_LOW, DIR_MINUS_TWO, 1'b0));
      send_order(make_beat(OP_DIRECTION, 0, FLOOR_TOP, DIR_UP, 1'b0));
      send_order(make_beat(OP_BETWEEN, 0, FLOOR_LOW, DIR_NONE, 1'b1));
      send_order(make_beat(OP_SPARE_LOW, 15, FLOOR_TOP, DIR_DOWN, 1'b1));
      send_order(make_beat(OP_SPARE_HIGH, 15, FLOOR_TOP, DIR_DOWN, 1'b1));
      send_order(make_beat(OP_CLEAR_FLOOR, 0, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_CLEAR_FLOOR, 0, FLOOR_TOP, DIR_NONE, 1'b0));
      // calls the other way when nothing lies further on
      send_order(make_beat(OP_ADD_ORDER, 6, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_HIGH, DIR_DOWN, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 3, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_LOW, DIR_DOWN, 1'b0));
      send_order(make_beat(OP_CLEAR_ALL, 0, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 4, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_LOW, DIR_UP, 1'b0));
      send_order(make_beat(OP_ADD_ORDER, 7, FLOOR_BOTTOM, DIR_NONE, 1'b0));
      send_order(make_beat(OP_STOP_CHECK, 0, FLOOR_HIGH, DIR_UP, 1'b0));
      send_order(make_beat(OP_CLEAR_ALL, 0, FLOOR_BOTTOM, DIR_NONE, 1'b0));
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_order(random_order_beat());
   endtask

   // reply side holds off while requests keep coming, so the core backs up
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_request = 150;
      for (int n = 0; n < 40; n++) send_order(random_order_beat());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 21;
      recv_idle_pct = 63;
      test_directed();
      test_random(650);
      send_idle_pct = 63;
      recv_idle_pct = 21;
      test_random(650);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(650);
      test_backpressure();

      // drain outstanding replies, then let the pipeline settle
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
